>>> design/spiral_index_to_coordinate_macros.svh
// Assertion macros for the spiral coordinate RTL (used by sitc_place)
`ifndef SPIRAL_INDEX_TO_COORDINATE_MACROS_SVH
`define SPIRAL_INDEX_TO_COORDINATE_MACROS_SVH

// same-cycle implication, disabled in reset
`define SITC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SITC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/sitc_pkg.sv
// Package: widths and payload types of the spiral coordinate pipeline
`timescale 1ns / 1ps
`default_nettype none

package sitc_pkg;

  localparam int SideWidth = 16;
  localparam int PosWidth  = 32;
  localparam int RootSteps = PosWidth / 2;
  localparam int RootWidth = RootSteps;
  localparam int OffWidth  = 19;

  typedef struct packed {
    logic [SideWidth-1:0] side;
    logic [SideWidth-1:0] centre;
    logic [PosWidth-1:0]  position;
    logic                 oog;
    logic                 small_pos;
  } sitc_ctx_t;

  typedef struct packed {
    logic [PosWidth-1:0] rem;
    logic [PosWidth-1:0] res;
  } sitc_root_t;

endpackage

`default_nettype wire

>>> design/sitc_prep.sv
// Front stages: input register, side squared, grid check and root seed
`timescale 1ns / 1ps
`default_nettype none

module sitc_prep (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [sitc_pkg::SideWidth-1:0]      side_i,
  input  logic [sitc_pkg::PosWidth-1:0]       position_i,
  output logic                                valid_o,
  output sitc_pkg::sitc_ctx_t                 ctx_o,
  output sitc_pkg::sitc_root_t                root_o
);

  logic                            a_valid_q;
  logic [sitc_pkg::SideWidth-1:0]  a_side_q;
  logic [sitc_pkg::PosWidth-1:0]   a_pos_q;

  logic                            b_valid_q;
  sitc_pkg::sitc_ctx_t             b_ctx_q;
  sitc_pkg::sitc_ctx_t             b_ctx_d;
  logic [sitc_pkg::PosWidth-1:0]   b_sq_q;
  logic [sitc_pkg::PosWidth-1:0]   b_sq_d;

  logic                            c_valid_q;
  sitc_pkg::sitc_ctx_t             c_ctx_q;
  sitc_pkg::sitc_ctx_t             c_ctx_d;
  sitc_pkg::sitc_root_t            c_root_q;
  sitc_pkg::sitc_root_t            c_root_d;

  always_comb begin
    b_ctx_d           = '0;
    b_ctx_d.side      = a_side_q;
    b_ctx_d.centre    = (a_side_q >> 1) + sitc_pkg::SideWidth'(1);
    b_ctx_d.position  = a_pos_q;
    b_ctx_d.oog       = 1'b0;
    b_ctx_d.small_pos = (a_pos_q[sitc_pkg::PosWidth-1:1] == '0);
    b_sq_d            = sitc_pkg::PosWidth'(a_side_q) * sitc_pkg::PosWidth'(a_side_q);
  end

  always_comb begin
    c_ctx_d      = b_ctx_q;
    c_ctx_d.oog  = (b_ctx_q.position > b_sq_q);
    c_root_d.rem = b_ctx_q.position - sitc_pkg::PosWidth'(1);
    c_root_d.res = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_side_q <= side_i;
      a_pos_q  <= position_i;
      b_ctx_q  <= b_ctx_d;
      b_sq_q   <= b_sq_d;
      c_ctx_q  <= c_ctx_d;
      c_root_q <= c_root_d;
    end
  end

  assign valid_o = c_valid_q;
  assign ctx_o   = c_ctx_q;
  assign root_o  = c_root_q;

endmodule

`default_nettype wire

>>> design/sitc_root_step.sv
// One pipelined step of the digit-by-digit integer square root
`timescale 1ns / 1ps
`default_nettype none

module sitc_root_step #(
  parameter int STEP = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  sitc_pkg::sitc_ctx_t   ctx_i,
  input  sitc_pkg::sitc_root_t  root_i,
  output logic                  valid_o,
  output sitc_pkg::sitc_ctx_t   ctx_o,
  output sitc_pkg::sitc_root_t  root_o
);

  localparam logic [sitc_pkg::PosWidth-1:0] Bit =
    sitc_pkg::PosWidth'(64'd1 << (sitc_pkg::PosWidth - 2 - 2 * STEP));

  logic                          valid_q;
  sitc_pkg::sitc_ctx_t           ctx_q;
  sitc_pkg::sitc_root_t          root_q;
  sitc_pkg::sitc_root_t          root_d;
  logic [sitc_pkg::PosWidth:0]   trial;

  always_comb begin
    trial = {1'b0, root_i.res} + {1'b0, Bit};
    if ({1'b0, root_i.rem} >= trial) begin
      root_d.rem = root_i.rem - trial[sitc_pkg::PosWidth-1:0];
      root_d.res = (root_i.res >> 1) + Bit;
    end else begin
      root_d.rem = root_i.rem;
      root_d.res = root_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx_q  <= ctx_i;
      root_q <= root_d;
    end
  end

  assign valid_o = valid_q;
  assign ctx_o   = ctx_q;
  assign root_o  = root_q;

endmodule

`default_nettype wire

>>> design/sitc_place.sv
// Back stages: ring, offset along the ring, leg select and result register
`timescale 1ns / 1ps
`default_nettype none
`include "spiral_index_to_coordinate_macros.svh"

module sitc_place (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  sitc_pkg::sitc_ctx_t              ctx_i,
  input  logic [sitc_pkg::RootWidth-1:0]   root_i,
  output logic                             valid_o,
  output logic [sitc_pkg::SideWidth-1:0]   line_o,
  output logic [sitc_pkg::SideWidth-1:0]   column_o,
  output logic                             out_of_grid_o
);

  localparam int SW = sitc_pkg::SideWidth;
  localparam int PW = sitc_pkg::PosWidth;
  localparam int DW = sitc_pkg::OffWidth;
  localparam int RW = sitc_pkg::RootWidth;

  typedef struct packed {
    logic [RW-1:0] k;
    logic [SW-1:0] a0;
    logic [SW-1:0] a1;
    logic [SW-1:0] a2;
    logic [SW-1:0] a3;
    logic [SW-1:0] cpk;
    logic [SW-1:0] cmk;
    logic [DW-1:0] t1;
    logic [DW-1:0] t2;
    logic [DW-1:0] t3;
  } leg_t;

  // ring and inner odd side
  logic                 v1_q;
  sitc_pkg::sitc_ctx_t  ctx1_q;
  logic [RW-1:0]        k1_q;
  logic [RW-1:0]        k1_d;
  logic [RW-1:0]        inner1_q;
  logic [RW-1:0]        inner1_d;

  // inner square and leg constants
  logic                 v2_q;
  sitc_pkg::sitc_ctx_t  ctx2_q;
  logic [PW-1:0]        isq2_q;
  logic [PW-1:0]        isq2_d;
  leg_t                 leg2_q;
  leg_t                 leg2_d;
  logic [SW-1:0]        k3;
  logic [SW-1:0]        k5;
  logic [SW-1:0]        k7;

  // offset along the ring
  logic                 v3_q;
  sitc_pkg::sitc_ctx_t  ctx3_q;
  leg_t                 leg3_q;
  logic [DW-1:0]        d3_q;
  logic [PW-1:0]        d_full;
  logic [PW-1:0]        ring_lim;

  // result register
  logic                 out_valid_q;
  logic [SW-1:0]        out_line_q;
  logic [SW-1:0]        out_line_d;
  logic [SW-1:0]        out_col_q;
  logic [SW-1:0]        out_col_d;
  logic                 out_oog_q;
  logic [SW-1:0]        d16;

  always_comb begin
    k1_d     = RW'(({1'b0, root_i} + (RW+1)'(1)) >> 1);
    inner1_d = RW'({k1_d, 1'b0} - (RW+1)'(1));
  end

  always_comb begin
    k3 = SW'({k1_q, 1'b0}) + SW'(k1_q);
    k5 = SW'({k1_q, 2'b0}) + SW'(k1_q);
    k7 = SW'({k1_q, 3'b0}) - SW'(k1_q);
  end

  always_comb begin
    isq2_d     = PW'(inner1_q) * PW'(inner1_q);
    leg2_d     = '0;
    leg2_d.k   = k1_q;
    leg2_d.cpk = ctx1_q.centre + SW'(k1_q);
    leg2_d.cmk = ctx1_q.centre - SW'(k1_q);
    leg2_d.a0  = ctx1_q.centre + SW'(k1_q) - SW'(1);
    leg2_d.a1  = ctx1_q.centre + k3 - SW'(1);
    leg2_d.a2  = ctx1_q.centre + SW'(1) - k5;
    leg2_d.a3  = ctx1_q.centre + SW'(1) - k7;
    leg2_d.t1  = DW'({k1_q, 1'b0}) - DW'(1);
    leg2_d.t2  = DW'({k1_q, 2'b0}) - DW'(1);
    leg2_d.t3  = DW'({k1_q, 2'b0}) + DW'({k1_q, 1'b0}) - DW'(1);
  end

  assign d_full   = ctx2_q.position - isq2_q - PW'(1);
  assign ring_lim = PW'(leg2_q.k) << 3;

  assign d16 = d3_q[SW-1:0];

  always_comb begin
    if (ctx3_q.oog) begin
      out_line_d = ctx3_q.side;
      out_col_d  = ctx3_q.side;
    end else if (ctx3_q.small_pos) begin
      out_line_d = ctx3_q.centre;
      out_col_d  = ctx3_q.centre;
    end else if (d3_q <= leg3_q.t1) begin
      out_line_d = leg3_q.cpk;
      out_col_d  = leg3_q.a0 - d16;
    end else if (d3_q <= leg3_q.t2) begin
      out_line_d = leg3_q.a1 - d16;
      out_col_d  = leg3_q.cmk;
    end else if (d3_q <= leg3_q.t3) begin
      out_line_d = leg3_q.cmk;
      out_col_d  = leg3_q.a2 + d16;
    end else begin
      out_line_d = leg3_q.a3 + d16;
      out_col_d  = leg3_q.cpk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      v1_q        <= valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx1_q     <= ctx_i;
      k1_q       <= k1_d;
      inner1_q   <= inner1_d;
      ctx2_q     <= ctx1_q;
      isq2_q     <= isq2_d;
      leg2_q     <= leg2_d;
      ctx3_q     <= ctx2_q;
      leg3_q     <= leg2_q;
      d3_q       <= d_full[DW-1:0];
      out_line_q <= out_line_d;
      out_col_q  <= out_col_d;
      out_oog_q  <= ctx3_q.oog;
    end
  end

  assign valid_o       = out_valid_q;
  assign line_o        = out_line_q;
  assign column_o      = out_col_q;
  assign out_of_grid_o = out_oog_q;

  `SITC_ASSERT_IMPL(a_offset_in_ring, clk_i, rst_ni, v2_q && !ctx2_q.oog && !ctx2_q.small_pos, d_full < ring_lim, "offset lies outside its ring")
  `SITC_ASSERT_IMPL(a_corner_clamp, clk_i, rst_ni, out_valid_q && out_oog_q, out_line_q == out_col_q, "clamped result is not a corner")
  `SITC_ASSERT_NEXT(a_result_loaded, clk_i, rst_ni, v3_q && en_i, out_valid_q, "result register missed a transfer")

endmodule

`default_nettype wire

>>> design/spiral_index_to_coordinate.sv
// Top level: Ulam spiral position to grid line and column
//
//   channel | dir | handshake                 | payload
//   --------+-----+---------------------------+-------------------------------
//   in      | in  | in_valid_i / in_stall_o   | side_i, position_i
//   out     | out | out_valid_o / out_stall_i | line_o, column_o, out_of_grid_o
//
// Pipeline: 3 front stages, 16 root stages (one root bit each),
// 4 back stages. One transfer per cycle sustained while no result waits under out_stall_i.
// Reset clears every valid bit; payload registers are not reset.
// A waiting result under out_stall_i freezes the whole pipeline and raises
// in_stall_o in the same cycle; nothing moves until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module spiral_index_to_coordinate #(
  parameter int SIDE_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [sitc_pkg::SideWidth-1:0]   side_i,
  input  logic [sitc_pkg::PosWidth-1:0]    position_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [sitc_pkg::SideWidth-1:0]   line_o,
  output logic [sitc_pkg::SideWidth-1:0]   column_o,
  output logic                             out_of_grid_o
);

  localparam int SW    = sitc_pkg::SideWidth;
  localparam int SideW = (SIDE_BITS < SW) ? SIDE_BITS : SW;
  localparam logic [SW-1:0] SideMask = SW'(((SW+1)'(1) << SideW) - (SW+1)'(1));
  localparam int Steps = sitc_pkg::RootSteps;

  logic                  en;
  logic [SW-1:0]         side_masked;

  logic [Steps:0]        chain_valid;
  sitc_pkg::sitc_ctx_t   chain_ctx  [Steps+1];
  sitc_pkg::sitc_root_t  chain_root [Steps+1];

  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign side_masked = side_i & SideMask;

  sitc_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .side_i     (side_masked),
    .position_i (position_i),
    .valid_o    (chain_valid[0]),
    .ctx_o      (chain_ctx[0]),
    .root_o     (chain_root[0])
  );

  for (genvar i = 0; i < Steps; i++) begin : g_root
    sitc_root_step #(
      .STEP (i)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[i]),
      .ctx_i   (chain_ctx[i]),
      .root_i  (chain_root[i]),
      .valid_o (chain_valid[i+1]),
      .ctx_o   (chain_ctx[i+1]),
      .root_o  (chain_root[i+1])
    );
  end

  sitc_place u_place (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (chain_valid[Steps]),
    .ctx_i         (chain_ctx[Steps]),
    .root_i        (chain_root[Steps].res[sitc_pkg::RootWidth-1:0]),
    .valid_o       (out_valid_o),
    .line_o        (line_o),
    .column_o      (column_o),
    .out_of_grid_o (out_of_grid_o)
  );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Testbench for spiral_index_to_coordinate: predicts each cell and checks every transfer.
`timescale 1ns / 1ps

typedef struct {
  logic [sitc_pkg::SideWidth-1:0] line;
  logic [sitc_pkg::SideWidth-1:0] column;
  logic                           out_of_grid;
} spiral_cell_t;

class spiral_board;
  spiral_cell_t expected_cells[$];
  int unsigned  errors;
  int unsigned  queries;
  int unsigned  outside;
  int unsigned  checked;
  int           side_bits;

  function new(int bits);
    side_bits = bits;
    errors    = 0;
    queries   = 0;
    outside   = 0;
    checked   = 0;
  endfunction

  function bit [63:0] root_floor(bit [63:0] v);
    bit [63:0] r;
    bit [63:0] t;
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function spiral_cell_t locate_cell(bit [15:0] side, bit [31:0] position);
    spiral_cell_t spot;
    bit [63:0]    s, p, c, k, inner, d, ln, co;
    s = 64'(side) & ((64'd1 << side_bits) - 1);
    p = 64'(position);
    c = s / 2 + 1;
    spot.out_of_grid = 1'b0;
    if (p > s * s) begin
      ln = s;
      co = s;
      spot.out_of_grid = 1'b1;
    end else if (p <= 1) begin
      ln = c;
      co = c;
    end else begin
      k     = (root_floor(p - 1) + 1) / 2;
      inner = 2 * k - 1;
      d     = p - inner * inner - 1;
      if (d <= 2 * k - 1) begin
        ln = c + k;
        co = c + k - 1 - d;
      end else if (d <= 4 * k - 1) begin
        co = c - k;
        ln = c + 3 * k - 1 - d;
      end else if (d <= 6 * k - 1) begin
        ln = c - k;
        co = c + d + 1 - 5 * k;
      end else begin
        co = c + k;
        ln = c + d + 1 - 7 * k;
      end
    end
    spot.line   = ln[15:0];
    spot.column = co[15:0];
    return spot;
  endfunction

  function void note_query(bit [15:0] side, bit [31:0] position);
    spiral_cell_t spot;
    spot = locate_cell(side, position);
    queries++;
    if (spot.out_of_grid) outside++;
    expected_cells.insert(expected_cells.size(), spot);
  endfunction

  function void check_cell(logic [15:0] line, logic [15:0] column, logic out_of_grid);
    spiral_cell_t want;
    if (expected_cells.size() == 0) begin
      $error("unexpected result: line %0d column %0d out_of_grid %0b",
             line, column, out_of_grid);
      errors++;
      return;
    end
    want = expected_cells.pop_front();
    checked++;
    if (line !== want.line) begin
      $error("line: expected %0d, got %0d", want.line, line);
      errors++;
    end
    if (column !== want.column) begin
      $error("column: expected %0d, got %0d", want.column, column);
      errors++;
    end
    if (out_of_grid !== want.out_of_grid) begin
      $error("out_of_grid: expected %0b, got %0b", want.out_of_grid, out_of_grid);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return expected_cells.size();
  endfunction
endclass

module tb_top;
  localparam int SideBits    = 16;
  localparam int RandomItems = 1030;
  localparam int Limit       = 400000;
  localparam int Drain       = 40;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [sitc_pkg::SideWidth-1:0] side_i = '0;
  logic [sitc_pkg::PosWidth-1:0]  position_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [sitc_pkg::SideWidth-1:0] line_o;
  logic [sitc_pkg::SideWidth-1:0] column_o;
  logic                           out_of_grid_o;

  spiral_board board = new(SideBits);
  bit          steady = 1'b0;
  int unsigned cycles = 0;

  spiral_index_to_coordinate #(
    .SIDE_BITS(SideBits)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .side_i       (side_i),
    .position_i   (position_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .line_o       (line_o),
    .column_o     (column_o),
    .out_of_grid_o(out_of_grid_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == Limit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 29);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_cell(line_o, column_o, out_of_grid_o);
  end

  task automatic send_query(input bit [15:0] side, input bit [31:0] position);
    while (!steady && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    side_i     <= side;
    position_i <= position;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_query(side, position);
  endtask

  task automatic random_query(output bit [15:0] side, output bit [31:0] position);
    int unsigned pick;
    bit [63:0]   area, k, d;
    pick = $urandom_range(9);
    if (pick < 5) side = 16'(2 * $urandom_range(31) + 1);
    else if (pick < 8) side = 16'($urandom) | 16'd1;
    else if (pick < 9) side = 16'hFFFF;
    else side = 16'($urandom);
    area = 64'(side) * 64'(side);
    pick = $urandom_range(99);
    if (pick < 45 && side >= 3) begin
      k = $urandom_range((side - 1) / 2, 1);
      d = $urandom_range(32'(8 * k - 1));
      position = 32'((2 * k - 1) * (2 * k - 1) + 1 + d);
    end else if (pick < 75 && area != 0) begin
      position = $urandom_range(32'(area), 1);
    end else if (pick < 88 && area + 4 <= 64'hFFFF_FFFF) begin
      position = 32'(area + 1 + $urandom_range(3));
    end else begin
      position = $urandom;
    end
  endtask

  initial begin
    bit [15:0] s;
    bit [31:0] p;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // grid edges, zero and even sides, beyond-grid clamp, each leg of ring 1, legs 1, 2 and 4 of ring 2
    send_query(16'd1, 32'd1);
    send_query(16'd1, 32'd2);
    send_query(16'd1, 32'd0);
    send_query(16'd0, 32'd0);
    send_query(16'd0, 32'd5);
    send_query(16'd0, 32'hFFFF_FFFF);
    send_query(16'hFFFF, 32'd1);
    send_query(16'hFFFF, 32'd4294836225);
    send_query(16'hFFFF, 32'd4294836226);
    send_query(16'hFFFF, 32'hFFFF_FFFF);
    send_query(16'hFFFF, 32'd0);
    send_query(16'hFFFE, 32'hFFFC_0004);
    send_query(16'd2, 32'd4);
    send_query(16'd2, 32'd5);
    send_query(16'd4, 32'd16);
    for (int q = 2; q <= 10; q++) send_query(16'd5, 32'(q));
    send_query(16'd5, 32'd25);

    for (int n = 0; n < RandomItems; n++) begin
      steady = (n >= 400 && n < 600);
      random_query(s, p);
      send_query(s, p);
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);

    $display("Covered %0d spiral queries, %0d of them beyond the grid; %0d cells checked.",
             board.queries, board.outside, board.checked);
    if (board.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+design
design/sitc_pkg.sv
design/sitc_prep.sv
design/sitc_root_step.sv
design/sitc_place.sv
design/spiral_index_to_coordinate.sv
tb/tb_top.sv
